[design/can_frame_statistics_defines.svh]
// Assertion macros shared by the checker of the CAN frame statistics block.
// Depends on nothing; included by the checker file.
`ifndef CAN_FRAME_STATISTICS_DEFINES_SVH
`define CAN_FRAME_STATISTICS_DEFINES_SVH
`define CFS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");
`define CFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`endif

[design/cfs_pkg.sv]
// Types and constants of the CAN frame statistics block.
// Depends on nothing; used by the decode, statistics, top-level and checker files.
package cfs_pkg;
	localparam logic [1:0] OP_FRAME = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [0:0] CFG_MAX_GAP = 1'd0;
	localparam logic [0:0] CFG_MOVING  = 1'd1;

	localparam logic [28:0] ID_ENGINE = 29'h040;
	localparam logic [28:0] ID_STEER  = 29'h138;
	localparam logic [28:0] ID_SPEED  = 29'h139;
	localparam logic [28:0] ID_WHEEL  = 29'h13A;
	localparam logic [28:0] ID_GEAR   = 29'h241;
	localparam logic [28:0] ID_TEMP   = 29'h345;
	localparam logic [28:0] ID_AIR    = 29'h390;
	localparam logic [28:0] ID_FUEL   = 29'h393;

	localparam logic [7:0] BRAKE_LIGHT_MASK = 8'h04;
	localparam logic [7:0] CLUTCH_MASK      = 8'h80;
	localparam logic [7:0] TEMP_RESET       = 8'd40;
	localparam logic [23:0] MAX_GAP_RESET   = 24'd1000000;
	localparam logic [12:0] MOVING_RESET    = 13'd28;

	typedef struct packed {
		logic [1:0]  operation;
		logic [47:0] timestamp_us;
		logic [28:0] frame_id;
		logic [3:0]  length_code;
		logic [63:0] payload;
		logic [5:0]  stat_index;
	} in_req_t;

	typedef struct packed {
		logic [63:0] read_value;
		logic        frame_counted;
		logic        frame_decoded;
	} out_req_t;

	// decoded frame, one hit flag per known ID
	typedef struct packed {
		logic        counted;
		logic        clear;
		logic        read;
		logic [5:0]  stat_index;
		logic [63:0] ts;
		logic        hit_engine;
		logic        hit_steer;
		logic        hit_speed;
		logic        hit_wheel;
		logic        hit_gear;
		logic        hit_temp;
		logic        hit_air;
		logic        hit_fuel;
		logic [63:0] p;
	} dec_t;
endpackage

[design/cfs_decode.sv]
// Input stage: masks payload by length code and matches the known IDs.
// Depends on cfs_pkg.
module cfs_decode (
	input  cfs_pkg::in_req_t in_req,
	output cfs_pkg::dec_t    dec
);
	logic [3:0]  nbytes;
	logic [63:0] mask;
	logic        is_frame;

	always_comb begin
		nbytes = (in_req.length_code > 4'd8) ? 4'd8 : in_req.length_code;
		mask = '0;
		for (int k = 0; k < 8; k++) begin
			if (4'(k) < nbytes) mask[8*k +: 8] = 8'hFF;
		end
		is_frame = (in_req.operation == cfs_pkg::OP_FRAME) && (in_req.length_code != 4'd0);
		dec = '0;
		dec.counted = is_frame;
		dec.clear = in_req.operation == cfs_pkg::OP_CLEAR;
		dec.read = in_req.operation == cfs_pkg::OP_READ;
		dec.stat_index = in_req.stat_index;
		dec.ts = 64'(in_req.timestamp_us);
		dec.p = in_req.payload & mask;
		dec.hit_engine = is_frame && in_req.frame_id == cfs_pkg::ID_ENGINE && nbytes >= 4'd5;
		dec.hit_steer  = is_frame && in_req.frame_id == cfs_pkg::ID_STEER  && nbytes >= 4'd6;
		dec.hit_speed  = is_frame && in_req.frame_id == cfs_pkg::ID_SPEED  && nbytes >= 4'd6;
		dec.hit_wheel  = is_frame && in_req.frame_id == cfs_pkg::ID_WHEEL  && nbytes >= 4'd8;
		dec.hit_gear   = is_frame && in_req.frame_id == cfs_pkg::ID_GEAR   && nbytes >= 4'd6;
		dec.hit_temp   = is_frame && in_req.frame_id == cfs_pkg::ID_TEMP   && nbytes >= 4'd5;
		dec.hit_air    = is_frame && in_req.frame_id == cfs_pkg::ID_AIR    && nbytes >= 4'd5;
		dec.hit_fuel   = is_frame && in_req.frame_id == cfs_pkg::ID_FUEL   && nbytes >= 4'd6;
	end
endmodule

[design/cfs_stats.sv]
// Statistics registers: update from one decoded request a cycle while enabled, read mux.
// Depends on cfs_pkg.
module cfs_stats #(
	parameter int GEAR_BINS   = 7,
	parameter int COUNT_WIDTH = 48,
	parameter int TIME_WIDTH  = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  cfs_pkg::dec_t       dec,
	input  logic [23:0]         max_gap_us,
	input  logic [12:0]         moving_speed_raw,
	output cfs_pkg::out_req_t   result
);
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

	logic [COUNT_WIDTH-1:0] frames_total_q, speed_count_q, pedal_count_q, steer_count_q;
	logic [COUNT_WIDTH-1:0] brake_edges_q, clutch_count_q;
	logic [COUNT_WIDTH-1:0] gear_counts_q [GEAR_BINS];
	logic [TIME_WIDTH-1:0]  first_time_q, last_frame_time_q, prev_speed_ts_q;
	logic [63:0] active_time_sum_q, distance_sum_q, moving_time_sum_q;
	logic [63:0] speed_acc_q, pedal_sum_q, steer_abs_sum_q;
	logic [12:0] speed_max_q, wheel_speed_max_q;
	logic [13:0] rpm_max_q;
	logic [7:0]  pedal_max_q, brake_raw_max_q, oil_raw_max_q, coolant_raw_max_q;
	logic [7:0]  air_raw_min_q, air_raw_max_q;
	logic [15:0] steer_abs_max_q;
	logic [9:0]  fuel_first_q, fuel_latest_q;
	logic seen_any_frame_q, seen_speed_frame_q, brake_light_prev_q, air_seen_q, fuel_seen_q;

	logic [TIME_WIDTH-1:0] ts, fgap, sgap;
	logic        fgap_ok, sgap_ok;
	logic [13:0] rpm;
	logic [7:0]  pedal, brake_raw, air;
	logic [15:0] steer_raw, steer_abs;
	logic [12:0] speed, w0, w1, w2, w3, wmax;
	logic [2:0]  gear;
	logic        light;
	logic [36:0] dist_inc;
	logic [63:0] rv;

	always_comb begin
		ts = dec.ts[TIME_WIDTH-1:0];
		fgap = ts - last_frame_time_q;
		sgap = ts - prev_speed_ts_q;
		fgap_ok = ts > last_frame_time_q && 64'(fgap) < 64'(max_gap_us);
		sgap_ok = ts > prev_speed_ts_q && 64'(sgap) < 64'(max_gap_us);
		rpm = dec.p[29:16];
		pedal = dec.p[39:32];
		steer_raw = dec.p[31:16];
		steer_abs = steer_raw[15] ? 16'(17'h10000 - 17'(steer_raw)) : steer_raw;
		speed = dec.p[28:16];
		dist_inc = 37'(speed) * 37'(sgap[23:0]);
		light = (dec.p[39:32] & cfs_pkg::BRAKE_LIGHT_MASK) != 8'd0;
		brake_raw = dec.p[47:40];
		w0 = dec.p[24:12];
		w1 = dec.p[37:25];
		w2 = dec.p[50:38];
		w3 = dec.p[63:51];
		wmax = wheel_speed_max_q;
		if (w0 > wmax) wmax = w0;
		if (w1 > wmax) wmax = w1;
		if (w2 > wmax) wmax = w2;
		if (w3 > wmax) wmax = w3;
		gear = dec.p[37:35];
		air = dec.p[39:32];
	end

	always_comb begin
		rv = '0;
		case (dec.stat_index)
			6'd0:  rv = 64'(frames_total_q);
			6'd1:  rv = 64'(seen_any_frame_q);
			6'd2:  rv = 64'(first_time_q);
			6'd3:  rv = 64'(last_frame_time_q);
			6'd4:  rv = active_time_sum_q;
			6'd5:  rv = distance_sum_q;
			6'd6:  rv = moving_time_sum_q;
			6'd7:  rv = 64'(speed_max_q);
			6'd8:  rv = speed_acc_q;
			6'd9:  rv = 64'(speed_count_q);
			6'd10: rv = 64'(rpm_max_q);
			6'd11: rv = 64'(pedal_max_q);
			6'd12: rv = pedal_sum_q;
			6'd13: rv = 64'(pedal_count_q);
			6'd14: rv = 64'(steer_abs_max_q);
			6'd15: rv = steer_abs_sum_q;
			6'd16: rv = 64'(steer_count_q);
			6'd17: rv = 64'(brake_edges_q);
			6'd18: rv = 64'(brake_raw_max_q);
			6'd19: rv = 64'(wheel_speed_max_q);
			6'd20: rv = 64'(clutch_count_q);
			6'd21: rv = 64'(oil_raw_max_q);
			6'd22: rv = 64'(coolant_raw_max_q);
			6'd23: rv = 64'(air_seen_q);
			6'd24: rv = 64'(air_raw_min_q);
			6'd25: rv = 64'(air_raw_max_q);
			6'd26: rv = 64'(fuel_seen_q);
			6'd27: rv = 64'(fuel_first_q);
			6'd28: rv = 64'(fuel_latest_q);
			6'd29: rv = 64'(seen_speed_frame_q);
			6'd30: rv = 64'(prev_speed_ts_q);
			6'd31: rv = 64'(brake_light_prev_q);
			default: begin
				for (int g = 0; g < GEAR_BINS; g++) begin
					if (dec.stat_index == 6'(32 + g)) rv = 64'(gear_counts_q[g]);
				end
			end
		endcase
		if (!dec.read) rv = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_total_q <= '0; speed_count_q <= '0; pedal_count_q <= '0;
			steer_count_q <= '0; brake_edges_q <= '0; clutch_count_q <= '0;
			for (int g = 0; g < GEAR_BINS; g++) gear_counts_q[g] <= '0;
			first_time_q <= '0; last_frame_time_q <= '0; prev_speed_ts_q <= '0;
			active_time_sum_q <= '0; distance_sum_q <= '0; moving_time_sum_q <= '0;
			speed_acc_q <= '0; pedal_sum_q <= '0; steer_abs_sum_q <= '0;
			speed_max_q <= '0; wheel_speed_max_q <= '0; rpm_max_q <= '0;
			pedal_max_q <= '0; brake_raw_max_q <= '0;
			oil_raw_max_q <= cfs_pkg::TEMP_RESET; coolant_raw_max_q <= cfs_pkg::TEMP_RESET;
			air_raw_min_q <= '0; air_raw_max_q <= '0; steer_abs_max_q <= '0;
			fuel_first_q <= '0; fuel_latest_q <= '0;
			seen_any_frame_q <= 1'b0; seen_speed_frame_q <= 1'b0;
			brake_light_prev_q <= 1'b0; air_seen_q <= 1'b0; fuel_seen_q <= 1'b0;
		end else if (en && dec.clear) begin
			frames_total_q <= '0; speed_count_q <= '0; pedal_count_q <= '0;
			steer_count_q <= '0; brake_edges_q <= '0; clutch_count_q <= '0;
			for (int g = 0; g < GEAR_BINS; g++) gear_counts_q[g] <= '0;
			first_time_q <= '0; last_frame_time_q <= '0; prev_speed_ts_q <= '0;
			active_time_sum_q <= '0; distance_sum_q <= '0; moving_time_sum_q <= '0;
			speed_acc_q <= '0; pedal_sum_q <= '0; steer_abs_sum_q <= '0;
			speed_max_q <= '0; wheel_speed_max_q <= '0; rpm_max_q <= '0;
			pedal_max_q <= '0; brake_raw_max_q <= '0;
			oil_raw_max_q <= cfs_pkg::TEMP_RESET; coolant_raw_max_q <= cfs_pkg::TEMP_RESET;
			air_raw_min_q <= '0; air_raw_max_q <= '0; steer_abs_max_q <= '0;
			fuel_first_q <= '0; fuel_latest_q <= '0;
			seen_any_frame_q <= 1'b0; seen_speed_frame_q <= 1'b0;
			brake_light_prev_q <= 1'b0; air_seen_q <= 1'b0; fuel_seen_q <= 1'b0;
		end else if (en && dec.counted) begin
			frames_total_q <= frames_total_q + CNT_ONE;
			if (!seen_any_frame_q) begin
				seen_any_frame_q <= 1'b1;
				first_time_q <= ts;
			end else if (fgap_ok) begin
				active_time_sum_q <= active_time_sum_q + 64'(fgap);
			end
			last_frame_time_q <= ts;
			if (dec.hit_engine) begin
				if (rpm > rpm_max_q) rpm_max_q <= rpm;
				if (pedal > pedal_max_q) pedal_max_q <= pedal;
				pedal_sum_q <= pedal_sum_q + 64'(pedal);
				pedal_count_q <= pedal_count_q + CNT_ONE;
			end
			if (dec.hit_steer) begin
				if (steer_abs > steer_abs_max_q) steer_abs_max_q <= steer_abs;
				steer_abs_sum_q <= steer_abs_sum_q + 64'(steer_abs);
				steer_count_q <= steer_count_q + CNT_ONE;
			end
			if (dec.hit_speed) begin
				if (speed > speed_max_q) speed_max_q <= speed;
				speed_acc_q <= speed_acc_q + 64'(speed);
				speed_count_q <= speed_count_q + CNT_ONE;
				if (seen_speed_frame_q && sgap_ok) begin
					distance_sum_q <= distance_sum_q + 64'(dist_inc);
					if (speed > moving_speed_raw)
						moving_time_sum_q <= moving_time_sum_q + 64'(sgap);
				end
				prev_speed_ts_q <= ts;
				seen_speed_frame_q <= 1'b1;
				if (light && !brake_light_prev_q) brake_edges_q <= brake_edges_q + CNT_ONE;
				brake_light_prev_q <= light;
				if (brake_raw > brake_raw_max_q) brake_raw_max_q <= brake_raw;
			end
			if (dec.hit_wheel) wheel_speed_max_q <= wmax;
			if (dec.hit_gear) begin
				for (int g = 0; g < GEAR_BINS; g++) begin
					if (gear == 3'(g)) gear_counts_q[g] <= gear_counts_q[g] + CNT_ONE;
				end
				if ((dec.p[47:40] & cfs_pkg::CLUTCH_MASK) != 8'd0)
					clutch_count_q <= clutch_count_q + CNT_ONE;
			end
			if (dec.hit_temp) begin
				if (dec.p[31:24] > oil_raw_max_q) oil_raw_max_q <= dec.p[31:24];
				if (dec.p[39:32] > coolant_raw_max_q) coolant_raw_max_q <= dec.p[39:32];
			end
			if (dec.hit_air) begin
				if (!air_seen_q || air < air_raw_min_q) air_raw_min_q <= air;
				if (!air_seen_q || air > air_raw_max_q) air_raw_max_q <= air;
				air_seen_q <= 1'b1;
			end
			if (dec.hit_fuel) begin
				if (!fuel_seen_q) begin
					fuel_first_q <= dec.p[41:32];
					fuel_seen_q <= 1'b1;
				end
				fuel_latest_q <= dec.p[41:32];
			end
		end
	end

	always_comb begin
		result.read_value = rv;
		result.frame_counted = dec.counted;
		result.frame_decoded = dec.hit_engine | dec.hit_steer | dec.hit_speed |
			dec.hit_wheel | dec.hit_gear | dec.hit_temp | dec.hit_air | dec.hit_fuel;
	end
endmodule

[design/can_frame_statistics.sv]
// Top level of the CAN frame statistics block: input register, statistics, output register.
// Depends on cfs_pkg, cfs_decode and cfs_stats.
//
// One request a cycle: a request is registered on entry, the statistics update and the
// result is formed from that register when it advances to the output, and the result sits
// in an output register; a new request is taken every cycle while the output register is
// free or being emptied.
module can_frame_statistics #(
	parameter int GEAR_BINS   = 7,
	parameter int COUNT_WIDTH = 48,
	parameter int TIME_WIDTH  = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  cfs_pkg::in_req_t   in_req,
	output logic               out_valid,
	input  logic               out_stall,
	output cfs_pkg::out_req_t  out_req
);
	logic [23:0] max_gap_q;
	logic [12:0] moving_q;
	logic valid_s1;
	cfs_pkg::in_req_t req_s1;
	cfs_pkg::dec_t dec;
	cfs_pkg::out_req_t result;
	logic adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_gap_q <= cfs_pkg::MAX_GAP_RESET;
			moving_q <= cfs_pkg::MOVING_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				cfs_pkg::CFG_MAX_GAP: max_gap_q <= cfg_data;
				cfs_pkg::CFG_MOVING: moving_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// advance stage 1 into output when output is free or not stalled
	assign adv = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
			if (adv) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) req_s1 <= in_req;
		if (adv) out_req <= result;
	end

	cfs_decode u_decode (
		.in_req(req_s1),
		.dec(dec)
	);

	cfs_stats #(
		.GEAR_BINS(GEAR_BINS),
		.COUNT_WIDTH(COUNT_WIDTH),
		.TIME_WIDTH(TIME_WIDTH)
	) u_stats (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.dec(dec),
		.max_gap_us(max_gap_q),
		.moving_speed_raw(moving_q),
		.result(result)
	);
endmodule

[design/cfs_checker.sv]
// Port-level checks of the CAN frame statistics block, bound to the top level.
// Depends on cfs_pkg and can_frame_statistics_defines.svh.
`include "can_frame_statistics_defines.svh"
module cfs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input cfs_pkg::out_req_t out_req
);
	`CFS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_req))
	`CFS_ASSERT_IMPL(a_decoded_counted, clk, arst_n, out_valid && out_req.frame_decoded, out_req.frame_counted)
	`CFS_ASSERT_IMPL(a_frame_no_value, clk, arst_n, out_valid && out_req.frame_counted, out_req.read_value == 64'd0)
	`CFS_ASSERT_IMPL(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)
endmodule

bind can_frame_statistics cfs_checker u_cfs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_req(out_req)
);
